// ===== sv/espi_gc_pkg.sv =====
package espi_gc_pkg;

   localparam int unsigned ByteWidth  = 8;
   localparam int unsigned AddrWidth  = 16;
   localparam int unsigned DataWidth  = 32;
   localparam int unsigned StatWidth  = 16;
   localparam int unsigned CsrIdxWidth = 2;

   localparam logic [ByteWidth-1:0] CrcPoly = 8'h07;

   // configuration register indexes
   localparam logic [CsrIdxWidth-1:0] CSR_OPCODE    = 2'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_WAIT_CODE = 2'd1;
   localparam logic [CsrIdxWidth-1:0] CSR_MAX_WAIT  = 2'd2;

   // configuration reset values
   localparam logic [ByteWidth-1:0] OpcodeReset   = 8'h21;
   localparam logic [ByteWidth-1:0] WaitCodeReset = 8'h0F;
   localparam logic [ByteWidth-1:0] MaxWaitReset  = 8'd16;

   // command bytes: opcode, address high, address low, CRC
   localparam logic [2:0] CmdLastByte  = 3'd3;
   // body bytes: four data, two status, then CRC
   localparam logic [2:0] BodyCrcByte  = 3'd6;
   localparam logic [2:0] BodyStatByte = 3'd4;

   typedef enum logic [2:0] {
      PH_IDLE   = 3'd0,
      PH_CMD    = 3'd1,
      PH_TAR    = 3'd2,
      PH_RSP    = 3'd3,
      PH_BODY   = 3'd4,
      PH_FINISH = 3'd5
   } phase_type;

   typedef struct packed {
      logic [ByteWidth-1:0] opcode;
      logic [ByteWidth-1:0] wait_code;
      logic [ByteWidth-1:0] max_wait;
   } cfg_type;

   typedef struct packed {
      logic                 cs_n;
      logic                 io0_level;
      logic                 io0_drive;
      logic                 busy_res;
      logic                 done_res;
      logic [ByteWidth-1:0] response_code;
      logic [DataWidth-1:0] config_data;
      logic [StatWidth-1:0] target_status;
      logic [ByteWidth-1:0] received_crc;
      logic                 crc_good;
      logic [ByteWidth-1:0] wait_count;
   } result_type;

   // CRC-8, MSB first, one whole byte
   function automatic logic [ByteWidth-1:0] crc_feed(input logic [ByteWidth-1:0] crc,
                                                     input logic [ByteWidth-1:0] b);
      logic [ByteWidth-1:0] c;
      c = crc ^ b;
      for (int k = 0; k < ByteWidth; k++) begin
         c = c[ByteWidth-1] ? ({c[ByteWidth-2:0], 1'b0} ^ CrcPoly)
                            : {c[ByteWidth-2:0], 1'b0};
      end
      return c;
   endfunction

endpackage

// ===== sv/espi_gc_if.sv =====
interface espi_gc_req_if;
   logic        valid;
   logic        ready;
   logic        start_req;
   logic [15:0] cfg_address;
   logic        io1_level;

   modport source (output valid, start_req, cfg_address, io1_level, input ready);
   modport sink   (input valid, start_req, cfg_address, io1_level, output ready);
endinterface

interface espi_gc_rsp_if;
   logic        valid;
   logic        ready;
   logic        cs_n;
   logic        io0_level;
   logic        io0_drive;
   logic        busy_res;
   logic        done_res;
   logic [7:0]  response_code;
   logic [31:0] config_data;
   logic [15:0] target_status;
   logic [7:0]  received_crc;
   logic        crc_good;
   logic [7:0]  wait_count;

   modport source (output valid, cs_n, io0_level, io0_drive, busy_res, done_res,
                   response_code, config_data, target_status, received_crc,
                   crc_good, wait_count,
                   input ready);
   modport sink   (input valid, cs_n, io0_level, io0_drive, busy_res, done_res,
                   response_code, config_data, target_status, received_crc,
                   crc_good, wait_count,
                   output ready);
endinterface

// ===== sv/espi_gc_seq.sv =====
module espi_gc_seq (
   input  logic                                 clock,
   input  logic                                 reset,
   input  espi_gc_pkg::cfg_type                 cfg,
   input  logic                                 take,
   input  logic                                 start_req,
   input  logic [espi_gc_pkg::AddrWidth-1:0]    cfg_address,
   input  logic                                 io1_level,
   output espi_gc_pkg::result_type              result
);
   import espi_gc_pkg::*;

   phase_type            phase_ff, phase_in;
   logic [2:0]           bit_ff, bit_in;
   logic [2:0]           byte_ff, byte_in;
   logic [ByteWidth-1:0] shift_ff, shift_in;
   logic [ByteWidth-1:0] crc_ff, crc_in;
   logic [ByteWidth-1:0] wcnt_ff, wcnt_in;
   logic [AddrWidth-1:0] addr_ff, addr_in;
   logic [ByteWidth-1:0] rsp_ff, rsp_in;
   logic [DataWidth-1:0] data_ff, data_in;
   logic [StatWidth-1:0] stat_ff, stat_in;

   // hold sequencer state, advance on each accepted transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         bit_ff   <= 3'd7;
         byte_ff  <= '0;
         shift_ff <= '0;
         crc_ff   <= '0;
         wcnt_ff  <= '0;
         addr_ff  <= '0;
         rsp_ff   <= '0;
         data_ff  <= '0;
         stat_ff  <= '0;
      end else if (take) begin
         phase_ff <= phase_in;
         bit_ff   <= bit_in;
         byte_ff  <= byte_in;
         shift_ff <= shift_in;
         crc_ff   <= crc_in;
         wcnt_ff  <= wcnt_in;
         addr_ff  <= addr_in;
         rsp_ff   <= rsp_in;
         data_ff  <= data_in;
         stat_ff  <= stat_in;
      end
   end

   // next state and pin levels for one serial clock period
   always_comb begin
      logic                 again;
      logic [ByteWidth-1:0] rx_byte;
      phase_in = phase_ff;
      bit_in   = bit_ff;
      byte_in  = byte_ff;
      shift_in = shift_ff;
      crc_in   = crc_ff;
      wcnt_in  = wcnt_ff;
      addr_in  = addr_ff;
      rsp_in   = rsp_ff;
      data_in  = data_ff;
      stat_in  = stat_ff;
      again    = 1'b0;
      rx_byte  = '0;
      result   = '0;
      result.cs_n      = 1'b1;
      result.io0_level = 1'b1;
      result.io0_drive = 1'b1;

      // latch the address and load the opcode on start
      if (phase_ff == PH_IDLE && start_req) begin
         addr_in  = cfg_address;
         phase_in = PH_CMD;
         byte_in  = '0;
         bit_in   = 3'd7;
         shift_in = cfg.opcode;
         crc_in   = '0;
         wcnt_in  = '0;
         rsp_in   = '0;
         data_in  = '0;
         stat_in  = '0;
      end

      unique case (phase_in)
         PH_CMD: begin
            result.cs_n      = 1'b0;
            result.busy_res  = 1'b1;
            result.io0_level = shift_in[bit_in];
            if (bit_in == 3'd0) begin
               if (byte_in < CmdLastByte) crc_in = crc_feed(crc_in, shift_in);
               byte_in = byte_in + 3'd1;
               bit_in  = 3'd7;
               if (byte_in == 3'd1) shift_in = addr_in[AddrWidth-1 -: ByteWidth];
               else if (byte_in == 3'd2) shift_in = addr_in[ByteWidth-1:0];
               else if (byte_in == CmdLastByte) shift_in = crc_in;
               else begin
                  phase_in = PH_TAR;
                  bit_in   = 3'd1;
               end
            end else begin
               bit_in = bit_in - 3'd1;
            end
         end
         PH_TAR: begin
            result.cs_n     = 1'b0;
            result.busy_res = 1'b1;
            if (bit_in != 3'd0) begin
               bit_in = 3'd0;
            end else begin
               result.io0_drive = 1'b0;
               phase_in = PH_RSP;
               bit_in   = 3'd7;
               shift_in = '0;
               wcnt_in  = '0;
            end
         end
         PH_RSP: begin
            result.cs_n      = 1'b0;
            result.busy_res  = 1'b1;
            result.io0_drive = 1'b0;
            shift_in[bit_in] = shift_in[bit_in] | io1_level;
            if (bit_in == 3'd0) begin
               // retry on wait code until the limit is reached
               if (shift_in == cfg.wait_code) begin
                  wcnt_in = wcnt_in + 8'd1;
                  if (wcnt_in < cfg.max_wait) again = 1'b1;
               end
               bit_in = 3'd7;
               if (!again) begin
                  rsp_in   = shift_in;
                  crc_in   = crc_feed('0, shift_in);
                  phase_in = PH_BODY;
                  byte_in  = '0;
               end
               shift_in = '0;
            end else begin
               bit_in = bit_in - 3'd1;
            end
         end
         PH_BODY: begin
            result.cs_n      = 1'b0;
            result.busy_res  = 1'b1;
            result.io0_drive = 1'b0;
            shift_in[bit_in] = shift_in[bit_in] | io1_level;
            if (bit_in == 3'd0) begin
               rx_byte = shift_in;
               bit_in  = 3'd7;
               // assemble data and status little-endian
               if (byte_in < BodyStatByte) begin
                  data_in[{byte_in[1:0], 3'b000} +: ByteWidth] =
                     data_in[{byte_in[1:0], 3'b000} +: ByteWidth] | rx_byte;
               end else if (byte_in < BodyCrcByte) begin
                  stat_in[{byte_in[0], 3'b000} +: ByteWidth] =
                     stat_in[{byte_in[0], 3'b000} +: ByteWidth] | rx_byte;
               end
               if (byte_in < BodyCrcByte) begin
                  crc_in   = crc_feed(crc_in, rx_byte);
                  byte_in  = byte_in + 3'd1;
                  shift_in = '0;
               end else begin
                  phase_in = PH_FINISH;
               end
            end else begin
               bit_in = bit_in - 3'd1;
            end
         end
         PH_FINISH: begin
            result.done_res      = 1'b1;
            result.response_code = rsp_in;
            result.config_data   = data_in;
            result.target_status = stat_in;
            result.received_crc  = shift_in;
            result.crc_good      = (crc_in == shift_in);
            result.wait_count    = wcnt_in;
            phase_in = PH_IDLE;
            bit_in   = 3'd7;
            byte_in  = '0;
         end
         default: begin
            // idle: release chip select, nothing to do
         end
      endcase
   end

endmodule

// ===== sv/espi_get_config_host_master_top.sv =====
// A result is registered in the cycle after its transaction is accepted.
// Throughput: one transaction per clock cycle while the result register is empty or
// rsp_bus.ready is high, so transactions may arrive back to back.
// Reset: synchronous, active high; the sequencer returns to idle, the result register
// empties and the configuration registers take their default values.
module espi_get_config_host_master_top (
   input  logic                                  clock,
   input  logic                                  reset,
   espi_gc_req_if.sink                           req_bus,
   espi_gc_rsp_if.source                         rsp_bus,
   input  logic                                  csr_we,
   input  logic [espi_gc_pkg::CsrIdxWidth-1:0]   csr_index,
   input  logic [espi_gc_pkg::ByteWidth-1:0]     csr_wdata
);
   import espi_gc_pkg::*;

   cfg_type    cfg_ff;
   result_type step_res;
   result_type out_ff;
   logic       out_valid_ff;
   logic       take;

   // configuration registers; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.opcode    <= OpcodeReset;
         cfg_ff.wait_code <= WaitCodeReset;
         cfg_ff.max_wait  <= MaxWaitReset;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_OPCODE:    cfg_ff.opcode    <= csr_wdata;
            CSR_WAIT_CODE: cfg_ff.wait_code <= csr_wdata;
            CSR_MAX_WAIT:  cfg_ff.max_wait  <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // accept while the result register is empty or draining
   assign req_bus.ready = !out_valid_ff || rsp_bus.ready;
   assign take          = req_bus.valid && req_bus.ready;

   espi_gc_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .take        (take),
      .start_req   (req_bus.start_req),
      .cfg_address (req_bus.cfg_address),
      .io1_level   (req_bus.io1_level),
      .result      (step_res)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (take) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         out_ff <= step_res;
      end
   end

   assign rsp_bus.valid         = out_valid_ff;
   assign rsp_bus.cs_n          = out_ff.cs_n;
   assign rsp_bus.io0_level     = out_ff.io0_level;
   assign rsp_bus.io0_drive     = out_ff.io0_drive;
   assign rsp_bus.busy_res      = out_ff.busy_res;
   assign rsp_bus.done_res      = out_ff.done_res;
   assign rsp_bus.response_code = out_ff.response_code;
   assign rsp_bus.config_data   = out_ff.config_data;
   assign rsp_bus.target_status = out_ff.target_status;
   assign rsp_bus.received_crc  = out_ff.received_crc;
   assign rsp_bus.crc_good      = out_ff.crc_good;
   assign rsp_bus.wait_count    = out_ff.wait_count;

endmodule
